>>> rtl/core/page_table_frame_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Page table frame allocator assertion macros
// Clocked property wrappers shared by the core's assertion block.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_TABLE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PTFA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptfa: same-cycle check failed");

// next-cycle implication
`define PTFA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptfa: next-cycle check failed");

`endif

>>> rtl/core/ptfa_pkg.sv
// ----------------------------------------------------------------------------
// Page table frame allocator package
// Field widths, entry masks, mode and status codes, control structs.
// ----------------------------------------------------------------------------
package ptfa_pkg;

  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 13;
  localparam int COUNT_W    = 14;
  localparam int FRAME_W    = 20;
  localparam int FLAG_W     = 9;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_W    = 32;
  localparam int LOW_W      = 13;
  localparam int HIGH_W     = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam int IN_USE_POS = 11;

  localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLAIM = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IN_USE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_HIGH = 1'b1;

  localparam logic [ENTRY_W-1:0] ENTRY_RESET = 32'h0000_0002;
  localparam logic [ENTRY_W-1:0] FREE_MASK   = 32'hFFFF_F7FA;
  localparam logic [ENTRY_W-1:0] KEEP_MASK   = 32'h0000_0E00;
  localparam logic [ENTRY_W-1:0] IN_USE_BIT  = 32'h0000_0800;

  localparam logic [LOW_W-1:0]  LOW_RESET  = 13'h0B00;
  localparam logic [HIGH_W-1:0] HIGH_RESET = 14'h2000;

  typedef struct packed {
    logic start;
    logic clear;
    logic walk;
    logic push;
  } ptfa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_done;
    logic out_free;
  } ptfa_sts_t;

endpackage

>>> rtl/core/ptfa_ram.sv
// ----------------------------------------------------------------------------
// Page table frame allocator RAM
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ptfa_ctrl.sv
// ----------------------------------------------------------------------------
// Page table frame allocator controller
// Sequences table clear, word accept, table walk and result push.
// ----------------------------------------------------------------------------
module ptfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output ptfa_pkg::ptfa_cmd_t  cmd,
  input  ptfa_pkg::ptfa_sts_t  sts
);

  import ptfa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/ptfa_dp.sv
// ----------------------------------------------------------------------------
// Page table frame allocator datapath
// Search registers, entry table, walk index and result registers.
// ----------------------------------------------------------------------------
module ptfa_dp #(
  parameter int TABLE_ENTRIES = 8192
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptfa_pkg::ptfa_cmd_t                cmd,
  output ptfa_pkg::ptfa_sts_t                sts,
  input  logic [ptfa_pkg::MODE_W-1:0]        in_mode,
  input  logic [ptfa_pkg::INDEX_W-1:0]       in_page_index,
  input  logic [ptfa_pkg::COUNT_W-1:0]       in_page_count,
  input  logic [ptfa_pkg::FRAME_W-1:0]       in_frame_number,
  input  logic [ptfa_pkg::FLAG_W-1:0]        in_flags,
  input  logic                               cfg_we,
  input  logic [ptfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptfa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptfa_pkg::STATUS_W-1:0]      out_status,
  output logic [ptfa_pkg::INDEX_W-1:0]       out_result_index,
  output logic [ptfa_pkg::ENTRY_W-1:0]       out_entry_value
);

  import ptfa_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = (AW + 1 > COUNT_W + 1) ? AW + 1 : COUNT_W + 1;
  localparam logic [CW-1:0] TBL      = CW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

  logic [LOW_W-1:0]    low_r, low_nxt;
  logic [HIGH_W-1:0]   high_r, high_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [FLAG_W-1:0]   flags_r, flags_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       end_r, end_nxt;
  logic [CW-1:0]       ridx_r, ridx_nxt;
  logic                rvld_r, rvld_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [INDEX_W-1:0]  rix_r, rix_nxt;
  logic [ENTRY_W-1:0]  val_r, val_nxt;
  logic                ovld_r, ovld_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;
  logic [INDEX_W-1:0]  orix_r, orix_nxt;
  logic [ENTRY_W-1:0]  oval_r, oval_nxt;

  logic [CW-1:0]       base_c, lim_c, first_c;
  logic                more_c, hit_c, issue_c, proc_c, wr_c;
  logic [ENTRY_W-1:0]  wval_c;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  ptfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_LOW:  low_nxt  = cfg_wdata[LOW_W-1:0];
        CFG_SEARCH_HIGH: high_nxt = cfg_wdata[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_c = CW'(in_page_index);
    case (in_mode)
      MODE_MAP, MODE_FREE: begin
        first_c = base_c;
        lim_c   = base_c + CW'(in_page_count);
      end
      MODE_ALLOC: begin
        first_c = CW'(low_r);
        lim_c   = CW'(high_r);
      end
      default: begin
        first_c = base_c;
        lim_c   = base_c + CW'(1);
      end
    endcase
  end

  assign more_c   = (idx_r < end_r);
  assign hit_c    = rvld_r && !ram_rdata[IN_USE_POS]
                    && ((mode_r == MODE_ALLOC) || (mode_r == MODE_CLAIM));
  assign issue_c  = cmd.walk && more_c && !hit_c;
  assign proc_c   = cmd.walk && rvld_r;
  assign ram_raddr = idx_r[AW-1:0];

  always_comb begin
    wr_c   = 1'b0;
    wval_c = ram_rdata;
    case (mode_r)
      MODE_MAP: begin
        wr_c   = 1'b1;
        wval_c = (ram_rdata & KEEP_MASK)
                 | {frame_r, {(ENTRY_W - FRAME_W){1'b0}}}
                 | ENTRY_W'(flags_r);
      end
      MODE_FREE: begin
        wr_c   = 1'b1;
        wval_c = ram_rdata & FREE_MASK;
      end
      default: begin
        wr_c   = !ram_rdata[IN_USE_POS];
        wval_c = ram_rdata | IN_USE_BIT;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ridx_r[AW-1:0];
    ram_wdata = wval_c;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = ENTRY_RESET;
    end else if (proc_c && wr_c) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    clr_nxt   = cmd.clear ? clr_r + AW'(1) : clr_r;
    mode_nxt  = mode_r;
    flags_nxt = flags_r;
    frame_nxt = frame_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    ridx_nxt  = idx_r;
    rvld_nxt  = issue_c;
    st_nxt    = st_r;
    rix_nxt   = rix_r;
    val_nxt   = val_r;
    if (cmd.start) begin
      mode_nxt  = in_mode;
      flags_nxt = in_flags;
      frame_nxt = in_frame_number;
      idx_nxt   = first_c;
      end_nxt   = (lim_c > TBL) ? TBL : lim_c;
      rvld_nxt  = 1'b0;
      rix_nxt   = '0;
      val_nxt   = '0;
      case (in_mode)
        MODE_ALLOC: st_nxt = ST_NO_FREE;
        MODE_CLAIM: st_nxt = ST_IN_USE;
        default:    st_nxt = ST_DONE;
      endcase
    end else begin
      if (issue_c) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (proc_c) begin
        case (mode_r)
          MODE_MAP: begin
            frame_nxt = frame_r + FRAME_W'(1);
            val_nxt   = wval_c;
          end
          MODE_FREE: begin
            val_nxt = wval_c;
          end
          default: begin
            if (wr_c) begin
              st_nxt  = ST_DONE;
              rix_nxt = ridx_r[INDEX_W-1:0];
              val_nxt = wval_c;
            end else if (mode_r == MODE_CLAIM) begin
              val_nxt = ram_rdata;
            end
          end
        endcase
      end
    end
  end

  assign sts.clear_done = cmd.clear && (clr_r == CLR_LAST);
  assign sts.walk_done  = cmd.walk && (hit_c || (!more_c && !rvld_r));
  assign sts.out_free   = !ovld_r || !out_stall;

  always_comb begin
    ost_nxt  = ost_r;
    orix_nxt = orix_r;
    oval_nxt = oval_r;
    ovld_nxt = ovld_r && out_stall;
    if (cmd.push) begin
      ovld_nxt = 1'b1;
      ost_nxt  = st_r;
      orix_nxt = rix_r;
      oval_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RESET;
      high_r <= HIGH_RESET;
      clr_r  <= '0;
      rvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      clr_r  <= clr_nxt;
      rvld_r <= rvld_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    flags_r <= flags_nxt;
    frame_r <= frame_nxt;
    idx_r   <= idx_nxt;
    end_r   <= end_nxt;
    ridx_r  <= ridx_nxt;
    st_r    <= st_nxt;
    rix_r   <= rix_nxt;
    val_r   <= val_nxt;
    ost_r   <= ost_nxt;
    orix_r  <= orix_nxt;
    oval_r  <= oval_nxt;
  end

  assign out_valid        = ovld_r;
  assign out_status       = ost_r;
  assign out_result_index = orix_r;
  assign out_entry_value  = oval_r;

endmodule

>>> rtl/core/page_table_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// Page table frame allocator core
// Page-table entry store with run map, run free, first-fit allocate, claim.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    mode, page_index, page_count,
//                                            frame_number, flags
//   out_     output     out_valid/out_stall  status, result_index, entry_value
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// After reset a clearing pass writes every entry while in_stall stays high.
// Each word walks the table through the one read port, one entry per cycle:
// map and free walk up to page_count entries from page_index, allocate scans
// from the search low register to the first free entry, claim reads one entry.
// A result waits in the output register under out_stall while the next
// word is accepted and walked.
// ----------------------------------------------------------------------------
`include "page_table_frame_allocator_core_assert.svh"

module page_table_frame_allocator_core #(
  parameter int TABLE_ENTRIES = 8192
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ptfa_pkg::MODE_W-1:0]        in_mode,
  input  logic [ptfa_pkg::INDEX_W-1:0]       in_page_index,
  input  logic [ptfa_pkg::COUNT_W-1:0]       in_page_count,
  input  logic [ptfa_pkg::FRAME_W-1:0]       in_frame_number,
  input  logic [ptfa_pkg::FLAG_W-1:0]        in_flags,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptfa_pkg::STATUS_W-1:0]      out_status,
  output logic [ptfa_pkg::INDEX_W-1:0]       out_result_index,
  output logic [ptfa_pkg::ENTRY_W-1:0]       out_entry_value,
  input  logic                               cfg_we,
  input  logic [ptfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import ptfa_pkg::*;

  ptfa_cmd_t cmd;
  ptfa_sts_t sts;

  ptfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ptfa_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_page_index    (in_page_index),
    .in_page_count    (in_page_count),
    .in_frame_number  (in_frame_number),
    .in_flags         (in_flags),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_entry_value  (out_entry_value)
  );

  `PTFA_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)
  `PTFA_ASSERT_NOW(a_push_into_free_slot, cmd.push, !out_valid || !out_stall)
  `PTFA_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.start, cmd.clear, cmd.walk, cmd.push}))
  `PTFA_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, in_stall)

endmodule
